/* hw/rtl/tpdc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tpdc_pkg
// Shared constants, types and the square-root digit step for the
// three-point distance color pipeline.
// ---------------------------------------------------------------------------
package tpdc_pkg;

    // Default anchor coordinate width
    localparam int COORD_BITS_DEFAULT = 12;

    // Register file
    localparam int NUM_REGS  = 6;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Pixel coordinate width
    localparam int PIXEL_BITS = 11;

    // Distance clamp: a distance at or above this gives level zero
    localparam int DIST_LIMIT    = 640;
    localparam int DIST_SQ_LIMIT = DIST_LIMIT * DIST_LIMIT;

    // Saturated value full scale, in units of 1/2400
    localparam int FULL_SCALE = 2400;

    // Square root datapath: radicand below 2^19, root below 640
    localparam int RAD_BITS  = 20;
    localparam int ROOT_BITS = 10;
    localparam int REM_BITS  = 11;

    // v*255/2400 = ((v*17) >> 5) / 5, and n/5 = (n*52429) >> 18 for small n
    localparam int RECIP5_BITS = 17;
    localparam logic [RECIP5_BITS-1:0] RECIP5 = 17'd52429;
    localparam int RECIP5_SHIFT = 18;

    // One lane of the square root pipeline
    typedef struct packed {
        logic                 far;
        logic [RAD_BITS-1:0]  rad;
        logic [ROOT_BITS-1:0] root;
        logic [REM_BITS-1:0]  rem;
    } sqrt_lane_t;

    // One restoring digit step: bring down two radicand bits, try root*4+1
    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t cur);
        sqrt_lane_t          nxt;
        logic [REM_BITS+1:0] part;
        logic [REM_BITS+1:0] trial;
        nxt   = cur;
        part  = {cur.rem, cur.rad[RAD_BITS-1 -: 2]};
        trial = {1'b0, cur.root, 2'b01};
        nxt.rad = {cur.rad[RAD_BITS-3:0], 2'b00};
        if (part >= trial) begin
            nxt.rem  = REM_BITS'(part - trial);
            nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            nxt.rem  = part[REM_BITS-1:0];
            nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/three_point_distance_color.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// three_point_distance_color
// Per-pixel RGB888 color from the distances to three programmable anchors.
// ---------------------------------------------------------------------------
// The block takes one pixel coordinate per clock. Its color appears at the
// output after passing twelve register stages. With the output taken every
// cycle the block sustains one pixel per clock. The square root sets the
// latency: five stages each resolve two root bits of the squared distance.
// The subtract, square and sum stages sit in front of them, and the level,
// saturation and scaling stages sit behind. Every stage holds its own valid
// bit and loads whenever it is empty or its successor loads, so a stalled
// output only backs up the stages that are occupied. Anchors are written
// over the APB port at byte address 4*i; the user must write them only while
// no pixel is in flight, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
module three_point_distance_color #(
    parameter int COORD_BITS = tpdc_pkg::COORD_BITS_DEFAULT
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [tpdc_pkg::ADDR_BITS-1:0]    paddr,
    input  wire  [tpdc_pkg::DATA_BITS-1:0]    pwdata,
    output logic [tpdc_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready,
    // pixel requests
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [tpdc_pkg::PIXEL_BITS-1:0]   s_pixel_x,
    input  wire  [tpdc_pkg::PIXEL_BITS-1:0]   s_pixel_y,
    // color results
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [7:0]                        m_red,
    output logic [7:0]                        m_green,
    output logic [7:0]                        m_blue
);

    localparam int DX_W  = ((COORD_BITS > tpdc_pkg::PIXEL_BITS + 1) ?
                            COORD_BITS : tpdc_pkg::PIXEL_BITS + 1) + 1;
    localparam int AW    = DX_W - 1;
    localparam int SQ_W  = 2 * AW + 1;
    localparam int NST   = 12;
    localparam int NSQ   = 5;
    localparam int SQ0   = 2;
    localparam int ST_C  = SQ0 + NSQ + 1;
    localparam int ST_V  = ST_C + 1;
    localparam int ST_N  = ST_V + 1;
    localparam int ST_O  = ST_N + 1;

    // ---------------------------------------------------------------
    // Anchor registers
    // ---------------------------------------------------------------
    logic signed [COORD_BITS-1:0] anchor_reg [tpdc_pkg::NUM_REGS];
    logic [2:0]                   reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tpdc_pkg::NUM_REGS; i++) begin
                anchor_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            if (int'(reg_idx) < tpdc_pkg::NUM_REGS) begin
                anchor_reg[reg_idx] <= pwdata[COORD_BITS-1:0];
            end
        end
    end

    // return the sign-extended anchor, zero past the list
    always_comb begin
        prdata = '0;
        if (int'(reg_idx) < tpdc_pkg::NUM_REGS) begin
            prdata = {{(tpdc_pkg::DATA_BITS-COORD_BITS){anchor_reg[reg_idx][COORD_BITS-1]}},
                      anchor_reg[reg_idx]};
        end
    end

    // ---------------------------------------------------------------
    // Stage valid bits and load chain
    // ---------------------------------------------------------------
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_in;
    logic [NST:0]   load;

    // advance a stage when it is empty or its successor advances
    always_comb begin
        load[NST] = m_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign s_ready  = load[0];
    assign m_valid  = valid_reg[NST-1];
    assign valid_in = {valid_reg[NST-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers, one lane per color
    // ---------------------------------------------------------------
    logic signed [DX_W-1:0]  dx_reg     [3];
    logic signed [DX_W-1:0]  dy_reg     [3];
    logic signed [DX_W-1:0]  dx_next    [3];
    logic signed [DX_W-1:0]  dy_next    [3];
    logic [2*AW-1:0]         sqx_reg    [3];
    logic [2*AW-1:0]         sqy_reg    [3];
    logic [2*AW-1:0]         sqx_next   [3];
    logic [2*AW-1:0]         sqy_next   [3];
    tpdc_pkg::sqrt_lane_t    sr_reg     [NSQ+1][3];
    tpdc_pkg::sqrt_lane_t    sr_next    [NSQ+1][3];
    logic [9:0]              lvl_reg    [3];
    logic [9:0]              lvl_next   [3];
    logic [11:0]             lsum_reg;
    logic [11:0]             lsum_next;
    logic [11:0]             sat_reg    [3];
    logic [11:0]             sat_next   [3];
    logic [10:0]             scl_reg    [3];
    logic [10:0]             scl_next   [3];
    logic [7:0]              out_reg    [3];
    logic [7:0]              out_next   [3];

    always_comb begin
        logic signed [DX_W-1:0]  px_s;
        logic signed [DX_W-1:0]  py_s;
        logic signed [DX_W-1:0]  nx;
        logic signed [DX_W-1:0]  ny;
        logic [AW-1:0]           ax;
        logic [AW-1:0]           ay;
        logic [SQ_W-1:0]         dsq;
        logic [13:0]             nine;
        logic [12:0]             two;
        logic signed [14:0]      vt;
        logic [15:0]             q;
        logic [tpdc_pkg::PIXEL_BITS+tpdc_pkg::RECIP5_BITS-1:0] p;

        px_s = $signed({{(DX_W-tpdc_pkg::PIXEL_BITS){1'b0}}, s_pixel_x});
        py_s = $signed({{(DX_W-tpdc_pkg::PIXEL_BITS){1'b0}}, s_pixel_y});
        lsum_next = '0;

        for (int ch = 0; ch < 3; ch++) begin
            // offsets from the anchor
            dx_next[ch] = px_s - {{(DX_W-COORD_BITS){anchor_reg[2*ch][COORD_BITS-1]}},
                                  anchor_reg[2*ch]};
            dy_next[ch] = py_s - {{(DX_W-COORD_BITS){anchor_reg[2*ch+1][COORD_BITS-1]}},
                                  anchor_reg[2*ch+1]};

            // magnitudes squared
            nx = -dx_reg[ch];
            ny = -dy_reg[ch];
            ax = dx_reg[ch][DX_W-1] ? nx[AW-1:0] : dx_reg[ch][AW-1:0];
            ay = dy_reg[ch][DX_W-1] ? ny[AW-1:0] : dy_reg[ch][AW-1:0];
            sqx_next[ch] = (2*AW)'(ax) * (2*AW)'(ax);
            sqy_next[ch] = (2*AW)'(ay) * (2*AW)'(ay);

            // squared distance, flag far pixels, seed the root
            dsq = {1'b0, sqx_reg[ch]} + {1'b0, sqy_reg[ch]};
            sr_next[0][ch].far  = (dsq >= SQ_W'(tpdc_pkg::DIST_SQ_LIMIT));
            sr_next[0][ch].rad  = {1'b0, dsq[tpdc_pkg::RAD_BITS-2:0]};
            sr_next[0][ch].root = '0;
            sr_next[0][ch].rem  = '0;

            // two root bits per stage
            for (int j = 0; j < NSQ; j++) begin
                sr_next[j+1][ch] = tpdc_pkg::sqrt_step(tpdc_pkg::sqrt_step(sr_reg[j][ch]));
            end

            // channel level, zero for far pixels
            lvl_next[ch] = sr_reg[NSQ][ch].far ? 10'd0 :
                           10'(tpdc_pkg::DIST_LIMIT) - sr_reg[NSQ][ch].root;
            lsum_next = lsum_next + {2'b00, lvl_next[ch]};

            // saturate around the mean and clamp to full scale
            nine = {1'b0, lvl_reg[ch], 3'b000} + {4'b0000, lvl_reg[ch]};
            two  = {lsum_reg, 1'b0};
            vt   = $signed({1'b0, nine}) - $signed({2'b00, two});
            if (vt[14]) begin
                sat_next[ch] = '0;
            end else if (vt[13:0] > 14'(tpdc_pkg::FULL_SCALE)) begin
                sat_next[ch] = 12'(tpdc_pkg::FULL_SCALE);
            end else begin
                sat_next[ch] = vt[11:0];
            end

            // scale by 17/32
            q = {sat_reg[ch], 4'b0000} + {4'b0000, sat_reg[ch]};
            scl_next[ch] = q[15:5];

            // divide by five through the reciprocal
            p = scl_reg[ch] * tpdc_pkg::RECIP5;
            out_next[ch] = p[tpdc_pkg::RECIP5_SHIFT +: 8];
        end
    end

    // load each stage with its predecessor's result
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (load[1]) begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        for (int j = 0; j <= NSQ; j++) begin
            if (load[SQ0+j]) begin
                sr_reg[j] <= sr_next[j];
            end
        end
        if (load[ST_C]) begin
            lvl_reg  <= lvl_next;
            lsum_reg <= lsum_next;
        end
        if (load[ST_V]) begin
            sat_reg <= sat_next;
        end
        if (load[ST_N]) begin
            scl_reg <= scl_next;
        end
        if (load[ST_O]) begin
            out_reg <= out_next;
        end
    end

    assign m_red   = out_reg[0];
    assign m_green = out_reg[1];
    assign m_blue  = out_reg[2];

endmodule
`default_nettype wire
